### src/multi_axis_step_generator_assert.svh
// Assertion macros for the step generator; clock clk, reset arst_n taken from scope.
`ifndef MULTI_AXIS_STEP_GENERATOR_ASSERT_SVH
`define MULTI_AXIS_STEP_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MSG_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("step generator: same-cycle check failed");

// next-cycle implication
`define MSG_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("step generator: next-cycle check failed");

`endif

### src/msg_pkg.sv
// Shared types, constants and helpers of the step generator.
package msg_pkg;

	localparam int POSITION_WIDTH      = 32;
	localparam int MAX_EVENTS_PER_TICK = 4;
	localparam int CNT_W   = $clog2(MAX_EVENTS_PER_TICK + 1);
	localparam int CFG_W   = 31;
	localparam int IDX_W   = 3;
	localparam int EV_W    = 3;
	localparam int PINS_W  = 6;
	localparam int ERR_W   = 33;
	localparam int NUM_AX  = 4;
	localparam int NUM_ES  = 3;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 168;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} msg_op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_EVENT_COUNT = 3'd0,
		REG_STEPS_X     = 3'd1,
		REG_STEPS_Y     = 3'd2,
		REG_STEPS_Z     = 3'd3,
		REG_STEPS_E     = 3'd4,
		REG_DIRECTION   = 3'd5,
		REG_ENDSTOP_EN  = 3'd6
	} msg_reg_t;

	typedef struct packed {
		logic capture;  // latch input payload
		logic start;    // preload error counters, clear event count
		logic check;    // endstop sampling for a tick
		logic step;     // one step event into the output register
		logic status;   // idle status result into the output register
		logic last;     // result is the final one of its tick
	} msg_cmd_t;

	typedef struct packed {
		logic more;       // completed < event_count
		logic more_next;  // completed + 1 < event_count
	} msg_stat_t;

	function automatic logic [CNT_W-1:0] clamp_events(input logic [EV_W-1:0] ev);
		logic [CNT_W-1:0] r;
		if (int'(ev) == 0) begin
			r = CNT_W'(1);
		end else if (int'(ev) > MAX_EVENTS_PER_TICK) begin
			r = CNT_W'(MAX_EVENTS_PER_TICK);
		end else begin
			r = CNT_W'(ev);
		end
		return r;
	endfunction

	function automatic logic [31:0] pos_out(input logic [POSITION_WIDTH-1:0] p);
		return 32'($signed(p));
	endfunction

endpackage

### src/msg_ctrl.sv
// Sequencer: input handshake, event loop and output valid.
module msg_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_valid,
	output logic                          s_ready,
	input  msg_pkg::msg_op_t              opcode,
	input  logic [msg_pkg::EV_W-1:0]      events_this_tick,
	output logic                          m_valid,
	input  logic                          m_ready,
	output msg_pkg::msg_cmd_t             cmd,
	input  msg_pkg::msg_stat_t            st
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		STEP
	} state_t;

	state_t                     state_q;
	msg_pkg::msg_op_t           op_q;
	logic [msg_pkg::CNT_W-1:0]  n_q;
	logic [msg_pkg::CNT_W-1:0]  k_q;
	logic                       m_valid_q;
	logic                       out_free;
	logic                       fin;

	assign s_ready  = (state_q == IDLE);
	assign m_valid  = m_valid_q;
	assign out_free = !m_valid_q || m_ready;
	// tick ends when count reached or the block runs out of events
	assign fin = (msg_pkg::CNT_W'(k_q + 1'b1) == n_q) || !st.more_next;

	always_comb begin
		cmd         = '0;
		cmd.capture = s_valid && s_ready;
		case (state_q)
			EXEC: begin
				cmd.start = (op_q == msg_pkg::OP_START);
				cmd.check = (op_q == msg_pkg::OP_TICK);
			end
			STEP: begin
				if (out_free) begin
					cmd.step   = st.more;
					cmd.status = !st.more;
					cmd.last   = st.more ? fin : 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			op_q      <= msg_pkg::OP_START;
			n_q       <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.step || cmd.status) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cmd.capture) begin
						op_q    <= opcode;
						n_q     <= msg_pkg::clamp_events(events_this_tick);
						k_q     <= '0;
						state_q <= EXEC;
					end
				end
				EXEC: begin
					state_q <= (op_q == msg_pkg::OP_TICK) ? STEP : IDLE;
				end
				STEP: begin
					if (cmd.step || cmd.status) begin
						k_q <= msg_pkg::CNT_W'(k_q + 1'b1);
						if (cmd.last) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

### src/msg_dp.sv
// Datapath: configuration, error counters, positions, endstops, output register.
module msg_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msg_pkg::IDX_W-1:0]         cfg_index,
	input  logic [msg_pkg::CFG_W-1:0]         cfg_data,
	input  logic [msg_pkg::PINS_W-1:0]        endstop_pins,
	input  msg_pkg::msg_cmd_t                 cmd,
	output msg_pkg::msg_stat_t                st,
	output logic [msg_pkg::OUT_W-1:0]         out_data,
	output logic                              out_last
);

	localparam int PW = msg_pkg::POSITION_WIDTH;
	localparam int EW = msg_pkg::ERR_W;

	logic [msg_pkg::CFG_W-1:0]  ec_q;
	logic [msg_pkg::CFG_W-1:0]  steps_q [msg_pkg::NUM_AX];
	logic [msg_pkg::NUM_AX-1:0] dir_q;
	logic                       en_q;

	logic [EW-1:0]              err_q   [msg_pkg::NUM_AX];
	logic [PW-1:0]              pos_q   [msg_pkg::NUM_AX];
	logic [msg_pkg::CFG_W-1:0]  done_q;
	logic [msg_pkg::PINS_W-1:0] prev_q;
	logic [msg_pkg::NUM_ES-1:0] hit_q;
	logic [msg_pkg::PINS_W-1:0] pins_q;

	logic [EW-1:0]              sum     [msg_pkg::NUM_AX];
	logic [EW-1:0]              err_nx  [msg_pkg::NUM_AX];
	logic [PW-1:0]              pos_nx  [msg_pkg::NUM_AX];
	logic [PW-1:0]              pos_sel [msg_pkg::NUM_AX];
	logic [msg_pkg::NUM_AX-1:0] fire;
	logic [msg_pkg::CFG_W-1:0]  done_inc;
	logic [msg_pkg::CFG_W-1:0]  done_sel;
	logic [msg_pkg::NUM_ES-1:0] hit_nx;
	logic [msg_pkg::PINS_W-1:0] prev_nx;
	logic                       any_hit;

	assign done_inc     = msg_pkg::CFG_W'(done_q + 1'b1);
	assign st.more      = (done_q < ec_q);
	assign st.more_next = ({1'b0, done_q} + 32'd1) < {1'b0, ec_q};

	// one step event: all four axes side by side
	always_comb begin
		for (int a = 0; a < msg_pkg::NUM_AX; a++) begin
			sum[a]  = err_q[a] + EW'(steps_q[a]);
			fire[a] = (sum[a] != '0) && !sum[a][EW-1];
			err_nx[a] = fire[a] ? EW'(sum[a] - EW'(ec_q)) : sum[a];
			if (!fire[a]) begin
				pos_nx[a] = pos_q[a];
			end else if (dir_q[a]) begin
				pos_nx[a] = PW'(pos_q[a] - 1'b1);
			end else begin
				pos_nx[a] = PW'(pos_q[a] + 1'b1);
			end
			pos_sel[a] = cmd.step ? pos_nx[a] : pos_q[a];
		end
		done_sel = cmd.step ? done_inc : done_q;
	end

	// endstops: only the one on the side of travel, two triggered samples in a row
	always_comb begin
		logic [2:0] idx;
		hit_nx  = hit_q;
		prev_nx = prev_q;
		any_hit = 1'b0;
		for (int a = 0; a < msg_pkg::NUM_ES; a++) begin
			idx = 3'(2 * a + (dir_q[a] ? 0 : 1));
			if (!pins_q[idx] && prev_q[idx] && (steps_q[a] != '0)) begin
				hit_nx[a] = 1'b1;
				any_hit   = 1'b1;
			end
			prev_nx[idx] = !pins_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q   <= '0;
			dir_q  <= '0;
			en_q   <= 1'b0;
			done_q <= '0;
			prev_q <= '0;
			hit_q  <= '0;
			for (int a = 0; a < msg_pkg::NUM_AX; a++) begin
				steps_q[a] <= '0;
				err_q[a]   <= '0;
				pos_q[a]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (msg_pkg::msg_reg_t'(cfg_index))
					msg_pkg::REG_EVENT_COUNT: ec_q       <= cfg_data;
					msg_pkg::REG_STEPS_X:     steps_q[0] <= cfg_data;
					msg_pkg::REG_STEPS_Y:     steps_q[1] <= cfg_data;
					msg_pkg::REG_STEPS_Z:     steps_q[2] <= cfg_data;
					msg_pkg::REG_STEPS_E:     steps_q[3] <= cfg_data;
					msg_pkg::REG_DIRECTION:   dir_q      <= cfg_data[msg_pkg::NUM_AX-1:0];
					msg_pkg::REG_ENDSTOP_EN:  en_q       <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.start) begin
				for (int a = 0; a < msg_pkg::NUM_AX; a++) begin
					err_q[a] <= EW'(-EW'(ec_q >> 1));
				end
				done_q <= '0;
			end
			if (cmd.check && en_q) begin
				hit_q  <= hit_nx;
				prev_q <= prev_nx;
				if (any_hit) begin
					done_q <= ec_q;
				end
			end
			if (cmd.step) begin
				for (int a = 0; a < msg_pkg::NUM_AX; a++) begin
					err_q[a] <= err_nx[a];
					pos_q[a] <= pos_nx[a];
				end
				done_q <= done_inc;
			end
		end
	end

	// input payload and output register: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pins_q <= endstop_pins;
		end
		if (cmd.step || cmd.status) begin
			out_data <= {1'b0,
				done_sel >= ec_q,
				hit_q,
				done_sel,
				msg_pkg::pos_out(pos_sel[3]),
				msg_pkg::pos_out(pos_sel[2]),
				msg_pkg::pos_out(pos_sel[1]),
				msg_pkg::pos_out(pos_sel[0]),
				cmd.step ? fire : 4'b0000};
			out_last <= cmd.last;
		end
	end

endmodule

### src/multi_axis_step_generator.sv
// Four-axis line-tracing step generator with endstop stop.
// Start request: accept, then preload; it gives no result.
// Tick request: accept, endstop check, then r results (1 to 4), one step event per cycle through
//   the per-axis error adders while the output is not stalled; an output stall holds it.
// Next request is taken once the last result of a tick is in the output register.
// arst_n clears config, counters, positions, endstop history and hit flags.
module multi_axis_step_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [msg_pkg::IN_W-1:0]      s_tdata,   // events_this_tick[2:0], endstop_pins[8:3]
	input  logic                          s_tuser,   // opcode: 0 start block, 1 tick
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// step_pulses[3:0], position_x[35:4], position_y[67:36], position_z[99:68],
	// position_e[131:100], events_done[162:132], endstop_hit[165:163], block_done[166]
	output logic [msg_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tlast,   // last result of the tick
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msg_pkg::IDX_W-1:0]     cfg_index,
	input  logic [msg_pkg::CFG_W-1:0]     cfg_data
);

	msg_pkg::msg_cmd_t  cmd;
	msg_pkg::msg_stat_t st;

	// the user must write registers only between requests (the block does not enforce it), so always take them
	assign cfg_ready = 1'b1;

	// sequencer: one request at a time, one event per cycle while the output is not stalled
	msg_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_valid          (s_tvalid),
		.s_ready          (s_tready),
		.opcode           (msg_pkg::msg_op_t'(s_tuser)),
		.events_this_tick (s_tdata[msg_pkg::EV_W-1:0]),
		.m_valid          (m_tvalid),
		.m_ready          (m_tready),
		.cmd              (cmd),
		.st               (st)
	);

	// counters, positions, endstop logic and the result register
	msg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.endstop_pins (s_tdata[msg_pkg::EV_W +: msg_pkg::PINS_W]),
		.cmd          (cmd),
		.st           (st),
		.out_data     (m_tdata),
		.out_last     (m_tlast)
	);

`include "multi_axis_step_generator_assert.svh"

	// a step is only taken while the block has events left
	`MSG_ASSERT_IMP(a_step_needs_events, cmd.step, st.more)
	// nothing overwrites a result that is still waiting
	`MSG_ASSERT_IMP(a_no_overwrite, (cmd.step || cmd.status), (!m_tvalid || m_tready))
	// an accepted request blocks the input in the next cycle
	`MSG_ASSERT_NXT(a_one_at_a_time, (s_tvalid && s_tready), !s_tready)
	// counter look-ahead is consistent
	`MSG_ASSERT_IMP(a_lookahead, st.more_next, st.more)

endmodule
